>>> sv/tsc_pkg.sv
// Shared constants, codes and types of the timing statistics counter bank.
`timescale 1ns / 1ps

package tsc_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = 6;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int TALLY_W   = 7;
  localparam int DATA_W    = 64;
  localparam int KIND_W    = 2;
  localparam int ACT_W     = 3;
  localparam int GRP       = 8;
  localparam int NUM_GRP   = (NUM_SLOTS + GRP - 1) / GRP;
  localparam int GIDX_W    = $clog2(GRP);

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE  = 3'd1,
    ACT_BEGIN = 3'd2,
    ACT_END   = 3'd3,
    ACT_COUNT = 3'd4,
    ACT_SET   = 3'd5,
    ACT_READ  = 3'd6,
    ACT_RESET = 3'd7
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_COUNT    = 2'd0,
    KIND_ELAPSED  = 2'd1,
    KIND_INTERVAL = 2'd2,
    KIND_INVALID  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_CLEAR,
    UPD_BEGIN,
    UPD_RECORD,
    UPD_EVENT,
    UPD_INTERVAL
  } upd_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] total;
    logic [DATA_W-1:0] min;
    logic [DATA_W-1:0] max;
    logic [DATA_W-1:0] last;
    logic [DATA_W-1:0] begin_stamp;
    logic [DATA_W-1:0] prior_stamp;
    logic              pending;
    logic              prior_valid;
  } entry_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] slot;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] now_us;
    logic [DATA_W-1:0] sample_value;
  } req_t;

  typedef struct packed {
    logic              ok;
    upd_op_t           op;
    logic [DATA_W-1:0] v;
    logic [SLOT_W-1:0] tgt;
    logic [KIND_W-1:0] new_kind;
  } eval_t;

  typedef struct packed {
    logic             any;
    logic [IDX_W-1:0] idx;
  } free_t;

  typedef struct packed {
    logic               accepted;
    logic [SLOT_W-1:0]  slot_used;
    logic [KIND_W-1:0]  slot_kind;
    logic [DATA_W-1:0]  sample_count;
    logic [DATA_W-1:0]  sample_total;
    logic [DATA_W-1:0]  sample_min;
    logic [DATA_W-1:0]  sample_max;
    logic [DATA_W-1:0]  last_sample;
    logic               timing_active;
    logic [TALLY_W-1:0] slots_in_use;
  } res_t;

endpackage

>>> sv/tsc_if.sv
// Valid/ready channel interfaces for the request and result beats.
`timescale 1ns / 1ps

interface tsc_in_if;
  logic                              valid;
  logic                              ready;
  logic [tsc_pkg::ACT_W-1:0]         action;
  logic [tsc_pkg::SLOT_W-1:0]        slot;
  logic [tsc_pkg::KIND_W-1:0]        kind;
  logic [tsc_pkg::DATA_W-1:0]        now_us;
  logic signed [tsc_pkg::DATA_W-1:0] sample_value;

  modport source(output valid, action, slot, kind, now_us, sample_value, input ready);
  modport sink(input valid, action, slot, kind, now_us, sample_value, output ready);
endinterface

interface tsc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [tsc_pkg::SLOT_W-1:0]   slot_used;
  logic [tsc_pkg::KIND_W-1:0]   slot_kind;
  logic [tsc_pkg::DATA_W-1:0]   sample_count;
  logic [tsc_pkg::DATA_W-1:0]   sample_total;
  logic [tsc_pkg::DATA_W-1:0]   sample_min;
  logic [tsc_pkg::DATA_W-1:0]   sample_max;
  logic [tsc_pkg::DATA_W-1:0]   last_sample;
  logic                         timing_active;
  logic [tsc_pkg::TALLY_W-1:0]  slots_in_use;

  modport source(output valid, accepted, slot_used, slot_kind, sample_count, sample_total,
                 sample_min, sample_max, last_sample, timing_active, slots_in_use,
                 input ready);
  modport sink(input valid, accepted, slot_used, slot_kind, sample_count, sample_total,
               sample_min, sample_max, last_sample, timing_active, slots_in_use,
               output ready);
endinterface

>>> sv/tsc_slot_ram.sv
// Per-slot statistics memory with one write port and one registered read port.
`timescale 1ns / 1ps

module tsc_slot_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [tsc_pkg::IDX_W-1:0] wr_addr,
  input  tsc_pkg::entry_t           wr_data,
  input  logic                      rd_en,
  input  logic [tsc_pkg::IDX_W-1:0] rd_addr,
  output tsc_pkg::entry_t           rd_data
);

  tsc_pkg::entry_t mem [tsc_pkg::NUM_SLOTS];
  tsc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/tsc_free_find.sv
// Two-level lowest-free-slot search over the allocation bits.
`timescale 1ns / 1ps

module tsc_free_find (
  input  logic                          clk,
  input  logic [tsc_pkg::NUM_SLOTS-1:0] alloc_bits,
  output tsc_pkg::free_t                free
);

  logic [tsc_pkg::NUM_GRP-1:0] grp_free_r;
  logic [tsc_pkg::NUM_GRP-1:0] grp_free_nxt;
  logic [tsc_pkg::GIDX_W-1:0]  grp_idx_r   [tsc_pkg::NUM_GRP];
  logic [tsc_pkg::GIDX_W-1:0]  grp_idx_nxt [tsc_pkg::NUM_GRP];

  // The first level finds the lowest free bit inside each group of eight.
  always_comb begin
    for (int g = 0; g < tsc_pkg::NUM_GRP; g++) begin
      grp_free_nxt[g] = 1'b0;
      grp_idx_nxt[g]  = '0;
      for (int b = tsc_pkg::GRP - 1; b >= 0; b--) begin
        if ((g * tsc_pkg::GRP + b) < tsc_pkg::NUM_SLOTS) begin
          if (!alloc_bits[g * tsc_pkg::GRP + b]) begin
            grp_free_nxt[g] = 1'b1;
            grp_idx_nxt[g]  = tsc_pkg::GIDX_W'(b);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_free_r <= grp_free_nxt;
    grp_idx_r  <= grp_idx_nxt;
  end

  // The second level picks the lowest group that holds a free slot.
  always_comb begin
    free.any = 1'b0;
    free.idx = '0;
    for (int g = tsc_pkg::NUM_GRP - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        free.any = 1'b1;
        free.idx = tsc_pkg::IDX_W'(g * tsc_pkg::GRP) + tsc_pkg::IDX_W'(grp_idx_r[g]);
      end
    end
  end

endmodule

>>> sv/tsc_stat_update.sv
// Next-entry logic: clear, begin stamp, sample recording, event counting and interval recording.
`timescale 1ns / 1ps

module tsc_stat_update (
  input  tsc_pkg::upd_op_t            op,
  input  tsc_pkg::entry_t             cur,
  input  logic [tsc_pkg::DATA_W-1:0]  v,
  input  logic [tsc_pkg::DATA_W-1:0]  now_us,
  input  logic [tsc_pkg::KIND_W-1:0]  new_kind,
  output tsc_pkg::entry_t             nxt
);

  logic [tsc_pkg::DATA_W:0]   sum;
  logic                       cnt_full;
  logic [tsc_pkg::DATA_W-1:0] cnt_inc;
  tsc_pkg::entry_t            rec;

  always_comb begin
    sum      = {1'b0, cur.total} + {1'b0, v};
    cnt_full = &cur.count;
    cnt_inc  = cnt_full ? cur.count : cur.count + tsc_pkg::DATA_W'(1);

    rec       = cur;
    rec.last  = v;
    rec.total = sum[tsc_pkg::DATA_W] ? '1 : sum[tsc_pkg::DATA_W-1:0];
    rec.count = cnt_inc;
    if (cur.count == '0) begin
      rec.min = v;
      rec.max = v;
    end else begin
      rec.min = (v < cur.min) ? v : cur.min;
      rec.max = (v > cur.max) ? v : cur.max;
    end

    nxt = cur;
    case (op)
      tsc_pkg::UPD_CLEAR: begin
        nxt      = '0;
        nxt.kind = new_kind;
      end
      tsc_pkg::UPD_BEGIN: begin
        nxt.begin_stamp = now_us;
        nxt.pending     = 1'b1;
      end
      tsc_pkg::UPD_RECORD: begin
        nxt         = rec;
        nxt.pending = 1'b0;
      end
      tsc_pkg::UPD_EVENT: begin
        nxt.count = cnt_inc;
        nxt.last  = cnt_inc;
      end
      tsc_pkg::UPD_INTERVAL: begin
        if (cur.prior_valid) begin
          nxt = rec;
        end
        nxt.prior_stamp = now_us;
        nxt.prior_valid = 1'b1;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

>>> sv/timing_statistics_counter_bank_core.sv
// Top level of the timing statistics counter bank: sequencing, slot bookkeeping, result stage.
//
// Requests arrive as beats on in_ch (action, slot, kind, now_us, sample_value) and each
// one yields exactly one result beat on out_ch carrying the status, the slot's statistics
// after the action and the number of slots in use. Both channels use valid/ready.
// A request passes the accept cycle, which issues the statistics memory read, the evaluation
// state, which resolves the action and the sample value, and the commit state, which
// writes the entry back and loads the result register. The single read-modify-write pass
// over the slot memory lets a new request in only after the last one is written back, and
// its result beat becomes valid when the commit state loads the result register.
// Alloc picks the lowest free slot from a two-level search over the allocation bits.
// After reset all slots are free and the in-use count is zero; no clearing pass runs,
// since alloc writes a cleared entry before a slot can be read.
// When the receiver stalls, the result beat holds in its register; a new request is still
// accepted and processed up to its write-back, which waits until the result is taken.
`timescale 1ns / 1ps

module timing_statistics_counter_bank_core (
  input  logic      clk,
  input  logic      rst_n,
  tsc_in_if.sink    in_ch,
  tsc_out_if.source out_ch
);

  tsc_pkg::state_t state_r;
  tsc_pkg::state_t state_nxt;

  tsc_pkg::req_t   req_r;
  tsc_pkg::eval_t  eval_r;
  tsc_pkg::eval_t  eval_nxt;
  tsc_pkg::res_t   res_r;
  tsc_pkg::res_t   res_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;

  logic [tsc_pkg::NUM_SLOTS-1:0] alloc_bits_r;
  logic [tsc_pkg::NUM_SLOTS-1:0] alloc_bits_nxt;
  logic [tsc_pkg::TALLY_W-1:0]   tally_r;
  logic [tsc_pkg::TALLY_W-1:0]   tally_nxt;

  logic in_fire;
  logic rd_en;
  logic eval_load;
  logic commit_fire;

  tsc_pkg::free_t             free;
  tsc_pkg::entry_t            rd_entry;
  tsc_pkg::entry_t            upd_entry;
  logic [tsc_pkg::IDX_W-1:0]  rd_addr;
  logic [tsc_pkg::IDX_W-1:0]  req_idx;
  logic [tsc_pkg::IDX_W-1:0]  tgt_idx;
  logic                       req_in_range;
  logic                       tgt_in_range;
  logic                       slot_ok;
  logic                       wr_en;
  logic                       alive;
  tsc_pkg::entry_t            shown;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = tsc_pkg::ST_EVAL;
        end
      end
      tsc_pkg::ST_EVAL: begin
        state_nxt = tsc_pkg::ST_COMMIT;
      end
      tsc_pkg::ST_COMMIT: begin
        if (commit_fire) begin
          state_nxt = tsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    eval_load   = 1'b0;
    commit_fire = 1'b0;
    case (state_r)
      tsc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      tsc_pkg::ST_EVAL: begin
        eval_load = 1'b1;
      end
      tsc_pkg::ST_COMMIT: begin
        commit_fire = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign in_fire = in_ch.valid && in_ch.ready;
  assign rd_en   = in_fire;

  // A rejected alloc reports slot zero, so alloc reads that entry.
  assign rd_addr = (tsc_pkg::action_t'(in_ch.action) == tsc_pkg::ACT_ALLOC) ? '0 :
                   in_ch.slot[tsc_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.action       <= tsc_pkg::action_t'(in_ch.action);
      req_r.slot         <= in_ch.slot;
      req_r.kind         <= in_ch.kind;
      req_r.now_us       <= in_ch.now_us;
      req_r.sample_value <= in_ch.sample_value;
    end
  end

  tsc_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tgt_idx),
    .wr_data (upd_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  tsc_free_find u_find (
    .clk        (clk),
    .alloc_bits (alloc_bits_r),
    .free       (free)
  );

  // Action resolution.
  assign req_idx      = req_r.slot[tsc_pkg::IDX_W-1:0];
  assign req_in_range = {1'b0, req_r.slot} < (tsc_pkg::SLOT_W + 1)'(tsc_pkg::NUM_SLOTS);
  assign slot_ok      = req_in_range && alloc_bits_r[req_idx];

  always_comb begin
    eval_nxt          = '0;
    eval_nxt.op       = tsc_pkg::UPD_NONE;
    eval_nxt.tgt      = req_r.slot;
    eval_nxt.new_kind = rd_entry.kind;
    eval_nxt.v        = req_r.sample_value;
    case (req_r.action)
      tsc_pkg::ACT_ALLOC: begin
        eval_nxt.new_kind = req_r.kind;
        eval_nxt.tgt      = '0;
        if ((tsc_pkg::kind_t'(req_r.kind) != tsc_pkg::KIND_INVALID) && free.any) begin
          eval_nxt.ok  = 1'b1;
          eval_nxt.op  = tsc_pkg::UPD_CLEAR;
          eval_nxt.tgt = tsc_pkg::SLOT_W'(free.idx);
        end
      end
      tsc_pkg::ACT_FREE: begin
        eval_nxt.ok = slot_ok;
        eval_nxt.op = tsc_pkg::UPD_CLEAR;
      end
      tsc_pkg::ACT_BEGIN: begin
        eval_nxt.ok = slot_ok && (tsc_pkg::kind_t'(rd_entry.kind) == tsc_pkg::KIND_ELAPSED);
        eval_nxt.op = tsc_pkg::UPD_BEGIN;
      end
      tsc_pkg::ACT_END: begin
        eval_nxt.ok = slot_ok && (tsc_pkg::kind_t'(rd_entry.kind) == tsc_pkg::KIND_ELAPSED) &&
                      rd_entry.pending;
        eval_nxt.op = tsc_pkg::UPD_RECORD;
        eval_nxt.v  = req_r.now_us - rd_entry.begin_stamp;
      end
      tsc_pkg::ACT_COUNT: begin
        if (tsc_pkg::kind_t'(rd_entry.kind) == tsc_pkg::KIND_COUNT) begin
          eval_nxt.ok = slot_ok;
          eval_nxt.op = tsc_pkg::UPD_EVENT;
        end else if (tsc_pkg::kind_t'(rd_entry.kind) == tsc_pkg::KIND_INTERVAL) begin
          eval_nxt.ok = slot_ok;
          eval_nxt.op = tsc_pkg::UPD_INTERVAL;
          eval_nxt.v  = req_r.now_us - rd_entry.prior_stamp;
        end
      end
      tsc_pkg::ACT_SET: begin
        eval_nxt.ok = slot_ok && !req_r.sample_value[tsc_pkg::DATA_W-1] &&
                      (tsc_pkg::kind_t'(rd_entry.kind) == tsc_pkg::KIND_ELAPSED);
        eval_nxt.op = tsc_pkg::UPD_RECORD;
      end
      tsc_pkg::ACT_READ: begin
        eval_nxt.ok = slot_ok;
      end
      tsc_pkg::ACT_RESET: begin
        eval_nxt.ok = slot_ok;
        eval_nxt.op = tsc_pkg::UPD_CLEAR;
      end
      default: begin
        eval_nxt.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (eval_load) begin
      eval_r <= eval_nxt;
    end
  end

  // Write-back and result.
  tsc_stat_update u_upd (
    .op       (eval_r.op),
    .cur      (rd_entry),
    .v        (eval_r.v),
    .now_us   (req_r.now_us),
    .new_kind (eval_r.new_kind),
    .nxt      (upd_entry)
  );

  assign tgt_idx      = eval_r.tgt[tsc_pkg::IDX_W-1:0];
  assign tgt_in_range = {1'b0, eval_r.tgt} < (tsc_pkg::SLOT_W + 1)'(tsc_pkg::NUM_SLOTS);
  assign wr_en        = commit_fire && eval_r.ok && (eval_r.op != tsc_pkg::UPD_NONE);

  always_comb begin
    alloc_bits_nxt = alloc_bits_r;
    tally_nxt      = tally_r;
    if (commit_fire && eval_r.ok && (req_r.action == tsc_pkg::ACT_ALLOC)) begin
      alloc_bits_nxt[tgt_idx] = 1'b1;
      tally_nxt               = tally_r + tsc_pkg::TALLY_W'(1);
    end else if (commit_fire && eval_r.ok && (req_r.action == tsc_pkg::ACT_FREE)) begin
      alloc_bits_nxt[tgt_idx] = 1'b0;
      tally_nxt               = tally_r - tsc_pkg::TALLY_W'(1);
    end
  end

  always_comb begin
    if (eval_r.ok && (req_r.action == tsc_pkg::ACT_ALLOC)) begin
      alive = 1'b1;
    end else if (eval_r.ok && (req_r.action == tsc_pkg::ACT_FREE)) begin
      alive = 1'b0;
    end else begin
      alive = tgt_in_range && alloc_bits_r[tgt_idx];
    end
    shown = (eval_r.ok && (eval_r.op != tsc_pkg::UPD_NONE)) ? upd_entry : rd_entry;

    res_nxt               = '0;
    res_nxt.accepted      = eval_r.ok;
    res_nxt.slot_used     = eval_r.tgt;
    res_nxt.slots_in_use  = tally_nxt;
    if (alive) begin
      res_nxt.slot_kind     = shown.kind;
      res_nxt.sample_count  = shown.count;
      res_nxt.sample_total  = shown.total;
      res_nxt.sample_min    = shown.min;
      res_nxt.sample_max    = shown.max;
      res_nxt.last_sample   = shown.last;
      res_nxt.timing_active = shown.pending;
    end
  end

  always_comb begin
    if (commit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_fire) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsc_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      alloc_bits_r <= '0;
      tally_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      alloc_bits_r <= alloc_bits_nxt;
      tally_r      <= tally_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = res_r.accepted;
  assign out_ch.slot_used     = res_r.slot_used;
  assign out_ch.slot_kind     = res_r.slot_kind;
  assign out_ch.sample_count  = res_r.sample_count;
  assign out_ch.sample_total  = res_r.sample_total;
  assign out_ch.sample_min    = res_r.sample_min;
  assign out_ch.sample_max    = res_r.sample_max;
  assign out_ch.last_sample   = res_r.last_sample;
  assign out_ch.timing_active = res_r.timing_active;
  assign out_ch.slots_in_use  = res_r.slots_in_use;

  // The in-use count always matches the allocation bits.
  a_tally_matches : assert property (@(posedge clk) disable iff (!rst_n)
    tally_r == tsc_pkg::TALLY_W'($countones(alloc_bits_r)))
    else $error("in-use count differs from allocation bits");

  // An accepted alloc never claims a slot that is already allocated.
  a_alloc_free_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (commit_fire && eval_r.ok && (req_r.action == tsc_pkg::ACT_ALLOC))
      |-> !alloc_bits_r[tgt_idx])
    else $error("alloc claimed an allocated slot");

  // An accepted free leaves its slot unallocated.
  a_free_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (commit_fire && eval_r.ok && (req_r.action == tsc_pkg::ACT_FREE))
      |=> !alloc_bits_r[$past(tgt_idx)])
    else $error("free did not release its slot");

  // A write-back always produces a result beat in the next cycle.
  a_commit_result : assert property (@(posedge clk) disable iff (!rst_n)
    commit_fire |=> out_valid_r)
    else $error("write-back without a result beat");

endmodule

>>> bench/timing_statistics_counter_bank_core_test.sv
// Self-checking testbench for the timing statistics counter bank top level.
`timescale 1ns / 1ps

class stats_scoreboard;
  bit               taken[tsc_pkg::NUM_SLOTS];
  tsc_pkg::kind_t   kind_of[tsc_pkg::NUM_SLOTS];
  logic [63:0]      cnt[tsc_pkg::NUM_SLOTS];
  logic [63:0]      tot[tsc_pkg::NUM_SLOTS];
  logic [63:0]      lo[tsc_pkg::NUM_SLOTS];
  logic [63:0]      hi[tsc_pkg::NUM_SLOTS];
  logic [63:0]      lst[tsc_pkg::NUM_SLOTS];
  logic [63:0]      begin_at[tsc_pkg::NUM_SLOTS];
  logic [63:0]      prior_at[tsc_pkg::NUM_SLOTS];
  bit               pend[tsc_pkg::NUM_SLOTS];
  bit               prior_seen[tsc_pkg::NUM_SLOTS];
  int unsigned      in_use;
  tsc_pkg::res_t    pending_stats[$];
  int unsigned      mismatches;

  function new();
    for (int i = 0; i < tsc_pkg::NUM_SLOTS; i++) begin
      taken[i] = 1'b0;
      kind_of[i] = tsc_pkg::KIND_COUNT;
      wipe_slot(i);
    end
    in_use = 0;
    mismatches = 0;
  endfunction

  function void wipe_slot(int s);
    cnt[s] = '0;
    tot[s] = '0;
    lo[s] = '0;
    hi[s] = '0;
    lst[s] = '0;
    begin_at[s] = '0;
    prior_at[s] = '0;
    pend[s] = 1'b0;
    prior_seen[s] = 1'b0;
  endfunction

  function void add_sample(int s, logic [63:0] v);
    lst[s] = v;
    if (cnt[s] == '0) begin
      lo[s] = v;
      hi[s] = v;
    end else begin
      if (v < lo[s]) lo[s] = v;
      if (v > hi[s]) hi[s] = v;
    end
    if (v > ~tot[s]) tot[s] = '1;
    else tot[s] = tot[s] + v;
    if (cnt[s] != '1) cnt[s] = cnt[s] + 1;
  endfunction

  function tsc_pkg::res_t predict_statistics(tsc_pkg::req_t r);
    tsc_pkg::res_t res;
    int            s;
    bit            ok;
    res = '0;
    ok = 1'b0;
    s = r.slot;
    if (r.action == tsc_pkg::ACT_ALLOC) begin
      s = 0;
      if (r.kind != tsc_pkg::KIND_INVALID) begin
        for (int i = 0; i < tsc_pkg::NUM_SLOTS; i++) begin
          if (!taken[i]) begin
            wipe_slot(i);
            kind_of[i] = tsc_pkg::kind_t'(r.kind);
            taken[i] = 1'b1;
            in_use++;
            s = i;
            ok = 1'b1;
            break;
          end
        end
      end
    end else if (taken[s]) begin
      case (r.action)
        tsc_pkg::ACT_FREE: begin
          wipe_slot(s);
          kind_of[s] = tsc_pkg::KIND_COUNT;
          taken[s] = 1'b0;
          in_use--;
          ok = 1'b1;
        end
        tsc_pkg::ACT_BEGIN: begin
          if (kind_of[s] == tsc_pkg::KIND_ELAPSED) begin
            begin_at[s] = r.now_us;
            pend[s] = 1'b1;
            ok = 1'b1;
          end
        end
        tsc_pkg::ACT_END: begin
          if (kind_of[s] == tsc_pkg::KIND_ELAPSED && pend[s]) begin
            pend[s] = 1'b0;
            add_sample(s, r.now_us - begin_at[s]);
            ok = 1'b1;
          end
        end
        tsc_pkg::ACT_COUNT: begin
          if (kind_of[s] == tsc_pkg::KIND_COUNT) begin
            if (cnt[s] != '1) cnt[s] = cnt[s] + 1;
            lst[s] = cnt[s];
            ok = 1'b1;
          end else if (kind_of[s] == tsc_pkg::KIND_INTERVAL) begin
            if (prior_seen[s]) add_sample(s, r.now_us - prior_at[s]);
            prior_at[s] = r.now_us;
            prior_seen[s] = 1'b1;
            ok = 1'b1;
          end
        end
        tsc_pkg::ACT_SET: begin
          if (!r.sample_value[63] && kind_of[s] == tsc_pkg::KIND_ELAPSED) begin
            pend[s] = 1'b0;
            add_sample(s, r.sample_value);
            ok = 1'b1;
          end
        end
        tsc_pkg::ACT_READ: ok = 1'b1;
        tsc_pkg::ACT_RESET: begin
          wipe_slot(s);
          ok = 1'b1;
        end
        default: ;
      endcase
    end
    res.accepted = ok;
    res.slot_used = s[tsc_pkg::SLOT_W-1:0];
    if (taken[s]) begin
      res.slot_kind = kind_of[s];
      res.sample_count = cnt[s];
      res.sample_total = tot[s];
      res.sample_min = lo[s];
      res.sample_max = hi[s];
      res.last_sample = lst[s];
      res.timing_active = pend[s];
    end
    res.slots_in_use = in_use[tsc_pkg::TALLY_W-1:0];
    return res;
  endfunction

  function void note_request(tsc_pkg::req_t r);
    tsc_pkg::res_t res;
    res = predict_statistics(r);
    pending_stats.push_back(res);
  endfunction

  function int pick_taken();
    int idx[$];
    foreach (taken[i]) if (taken[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  function void flag(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s differs: expected %h, got %h", $realtime, field, want, got);
    end
  endfunction

  function void check_result(tsc_pkg::res_t got);
    tsc_pkg::res_t want;
    if (pending_stats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result beat arrived with none expected", $realtime);
      return;
    end
    want = pending_stats.pop_front();
    flag("accepted", want.accepted, got.accepted);
    flag("slot_used", want.slot_used, got.slot_used);
    flag("slot_kind", want.slot_kind, got.slot_kind);
    flag("sample_count", want.sample_count, got.sample_count);
    flag("sample_total", want.sample_total, got.sample_total);
    flag("sample_min", want.sample_min, got.sample_min);
    flag("sample_max", want.sample_max, got.sample_max);
    flag("last_sample", want.last_sample, got.last_sample);
    flag("timing_active", want.timing_active, got.timing_active);
    flag("slots_in_use", want.slots_in_use, got.slots_in_use);
  endfunction
endclass

module timing_statistics_counter_bank_core_test;
  logic            clk = 1'b0;
  logic            rst_n;
  stats_scoreboard sb;
  tsc_pkg::res_t   seen_beat;
  logic [63:0]     clock_us;
  int unsigned     burst_left;
  int unsigned     taken_beats;
  int unsigned     ready_cycle = 0;
  logic [1:0]      stall_style = 2'd0;

  tsc_in_if  in_ch();
  tsc_out_if out_ch();

  timing_statistics_counter_bank_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver switches at random among steady, random, sparse and periodic acceptance.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_beat.accepted = out_ch.accepted;
      seen_beat.slot_used = out_ch.slot_used;
      seen_beat.slot_kind = out_ch.slot_kind;
      seen_beat.sample_count = out_ch.sample_count;
      seen_beat.sample_total = out_ch.sample_total;
      seen_beat.sample_min = out_ch.sample_min;
      seen_beat.sample_max = out_ch.sample_max;
      seen_beat.last_sample = out_ch.last_sample;
      seen_beat.timing_active = out_ch.timing_active;
      seen_beat.slots_in_use = out_ch.slots_in_use;
      sb.check_result(seen_beat);
    end
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle % 64 == 0) stall_style <= 2'($urandom_range(0, 3));
    case (stall_style)
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
      2'd2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (ready_cycle % 8 < 5);
    endcase
  end

  function automatic tsc_pkg::req_t mk(tsc_pkg::action_t a, int slot, logic [1:0] k,
                                       logic [63:0] now, logic [63:0] v);
    tsc_pkg::req_t r;
    r.action = a;
    r.slot = slot[tsc_pkg::SLOT_W-1:0];
    r.kind = k;
    r.now_us = now;
    r.sample_value = v;
    return r;
  endfunction

  function automatic logic [63:0] next_time();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) clock_us = {$urandom, $urandom};
    else if (roll < 7) clock_us = (roll == 5) ? '1 : '0;
    else clock_us = clock_us + $urandom_range(0, 1000);
    return clock_us;
  endfunction

  function automatic logic [63:0] next_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 64'($urandom_range(0, 100000));
    if (roll < 80) return {$urandom, $urandom};
    if (roll < 90) return {1'b0, 31'($urandom), $urandom};
    if (roll < 95) return '0;
    return 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  // Profile 0 is mostly well-formed traffic on live slots, 1 fills the bank, 2 drains it.
  function automatic tsc_pkg::req_t make_random(int profile);
    tsc_pkg::req_t r;
    int            s;
    int unsigned   roll;
    r = mk(tsc_pkg::ACT_READ, $urandom_range(0, 63), 2'($urandom_range(0, 3)), next_time(),
           next_value());
    roll = $urandom_range(0, 99);
    if ((profile == 1 && roll < 85) || (profile == 0 && roll < 8)) begin
      r.action = tsc_pkg::ACT_ALLOC;
      if (r.kind == tsc_pkg::KIND_INVALID && $urandom_range(0, 3) != 0)
        r.kind = 2'($urandom_range(0, 2));
      return r;
    end
    s = sb.pick_taken();
    if ((profile == 2 && roll < 40) || (profile == 0 && roll < 13)) begin
      r.action = tsc_pkg::ACT_FREE;
      if (s >= 0) r.slot = s[tsc_pkg::SLOT_W-1:0];
      return r;
    end
    if (s < 0 || roll >= 90) begin
      r.action = tsc_pkg::action_t'($urandom_range(0, 7));
      return r;
    end
    r.slot = s[tsc_pkg::SLOT_W-1:0];
    roll = $urandom_range(0, 99);
    case (sb.kind_of[s])
      tsc_pkg::KIND_COUNT:
        r.action = (roll < 80) ? tsc_pkg::ACT_COUNT : (roll < 92) ? tsc_pkg::ACT_READ :
                   (roll < 96) ? tsc_pkg::ACT_RESET : tsc_pkg::action_t'($urandom_range(1, 7));
      tsc_pkg::KIND_ELAPSED: begin
        if (sb.pend[s])
          r.action = (roll < 60) ? tsc_pkg::ACT_END : (roll < 75) ? tsc_pkg::ACT_SET :
                     (roll < 85) ? tsc_pkg::ACT_BEGIN :
                     tsc_pkg::action_t'($urandom_range(1, 7));
        else
          r.action = (roll < 55) ? tsc_pkg::ACT_BEGIN : (roll < 80) ? tsc_pkg::ACT_SET :
                     (roll < 85) ? tsc_pkg::ACT_END :
                     tsc_pkg::action_t'($urandom_range(1, 7));
      end
      default:
        r.action = (roll < 85) ? tsc_pkg::ACT_COUNT : (roll < 92) ? tsc_pkg::ACT_READ :
                   (roll < 95) ? tsc_pkg::ACT_RESET : tsc_pkg::action_t'($urandom_range(1, 7));
    endcase
    return r;
  endfunction

  task automatic send_beat(input tsc_pkg::req_t r);
    in_ch.valid <= 1'b1;
    in_ch.action <= r.action;
    in_ch.slot <= r.slot;
    in_ch.kind <= r.kind;
    in_ch.now_us <= r.now_us;
    in_ch.sample_value <= r.sample_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic issue(input tsc_pkg::req_t r);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    send_beat(r);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_stats.size() != 0) @(posedge clk);
  endtask

  initial begin
    int profile;
    int round_left;
    sb = new();
    clock_us = '0;
    burst_left = 0;
    taken_beats = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= tsc_pkg::ACT_READ;
    in_ch.slot <= '0;
    in_ch.kind <= '0;
    in_ch.now_us <= '0;
    in_ch.sample_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    issue(mk(tsc_pkg::ACT_READ, 0, tsc_pkg::KIND_COUNT, 0, 0));
    issue(mk(tsc_pkg::ACT_ALLOC, 9, tsc_pkg::KIND_INVALID, 0, 0));
    issue(mk(tsc_pkg::ACT_ALLOC, 40, tsc_pkg::KIND_COUNT, 0, 0));
    issue(mk(tsc_pkg::ACT_ALLOC, 0, tsc_pkg::KIND_ELAPSED, 0, 0));
    issue(mk(tsc_pkg::ACT_ALLOC, 63, tsc_pkg::KIND_INTERVAL, 0, 0));
    issue(mk(tsc_pkg::ACT_COUNT, 0, tsc_pkg::KIND_COUNT, 5, 0));
    issue(mk(tsc_pkg::ACT_COUNT, 0, tsc_pkg::KIND_COUNT, 6, 0));
    issue(mk(tsc_pkg::ACT_COUNT, 1, tsc_pkg::KIND_COUNT, 7, 0));
    issue(mk(tsc_pkg::ACT_BEGIN, 0, tsc_pkg::KIND_COUNT, 8, 0));
    issue(mk(tsc_pkg::ACT_END, 1, tsc_pkg::KIND_COUNT, 9, 0));
    issue(mk(tsc_pkg::ACT_BEGIN, 1, tsc_pkg::KIND_COUNT, 100, 0));
    issue(mk(tsc_pkg::ACT_END, 1, tsc_pkg::KIND_COUNT, 50, 0));
    issue(mk(tsc_pkg::ACT_BEGIN, 1, tsc_pkg::KIND_COUNT, 0, 0));
    issue(mk(tsc_pkg::ACT_END, 1, tsc_pkg::KIND_COUNT, '1, 0));
    issue(mk(tsc_pkg::ACT_SET, 1, tsc_pkg::KIND_COUNT, 0, 64'h8000_0000_0000_0000));
    issue(mk(tsc_pkg::ACT_SET, 1, tsc_pkg::KIND_COUNT, 0, 64'h7FFF_FFFF_FFFF_FFFF));
    issue(mk(tsc_pkg::ACT_BEGIN, 1, tsc_pkg::KIND_COUNT, 9, 0));
    issue(mk(tsc_pkg::ACT_SET, 1, tsc_pkg::KIND_COUNT, 0, 0));
    issue(mk(tsc_pkg::ACT_SET, 2, tsc_pkg::KIND_COUNT, 0, 5));
    issue(mk(tsc_pkg::ACT_COUNT, 2, tsc_pkg::KIND_COUNT, 0, 0));
    issue(mk(tsc_pkg::ACT_COUNT, 2, tsc_pkg::KIND_COUNT, '1, 0));
    issue(mk(tsc_pkg::ACT_COUNT, 2, tsc_pkg::KIND_COUNT, 3, 0));
    issue(mk(tsc_pkg::ACT_RESET, 2, tsc_pkg::KIND_COUNT, 0, 0));
    issue(mk(tsc_pkg::ACT_COUNT, 2, tsc_pkg::KIND_COUNT, 7, 0));
    issue(mk(tsc_pkg::ACT_FREE, 0, tsc_pkg::KIND_COUNT, 0, 0));
    issue(mk(tsc_pkg::ACT_FREE, 0, tsc_pkg::KIND_COUNT, 0, 0));
    issue(mk(tsc_pkg::ACT_READ, 63, tsc_pkg::KIND_COUNT, 0, 0));
    drain_results();

    profile = 1;
    round_left = 100;
    while (taken_beats < 1350) begin
      if (round_left == 0) begin
        if ($urandom_range(0, 5) == 0) drain_results();
        round_left = $urandom_range(20, 80);
        profile = ($urandom_range(0, 6) < 5) ? 0 : $urandom_range(1, 2);
      end
      round_left--;
      issue(make_random(profile));
      taken_beats++;
    end
    drain_results();
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_stats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> sim.f
sv/tsc_pkg.sv
sv/tsc_if.sv
sv/tsc_slot_ram.sv
sv/tsc_free_find.sv
sv/tsc_stat_update.sv
sv/timing_statistics_counter_bank_core.sv
bench/timing_statistics_counter_bank_core_test.sv
